@@ src/bprd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bprd_pkg
// Shared constants, codes and types of the bitmap pixel row decoder.
// ----------------------------------------------------------------------------
package bprd_pkg;

  localparam int PALETTE_DEPTH = 256;
  localparam int MAX_WIDTH     = 4096;
  localparam int MAX_ROWS      = 4096;

  localparam int PAL_AW    = $clog2(PALETTE_DEPTH);
  localparam int ENT_W     = $clog2(PALETTE_DEPTH + 1);
  localparam int PAL_CNT_W = ENT_W + 2;

  localparam int FMT_W        = 2;
  localparam int WIDTH_CFG_W  = 13;
  localparam int HEIGHT_CFG_W = 14;
  localparam int ENT_CFG_W    = 9;
  localparam int CFG_DATA_W   = 14;
  localparam int CFG_ADDR_W   = 2;

  localparam int W_W    = $clog2(MAX_WIDTH + 1);
  localparam int GW     = (W_W > WIDTH_CFG_W) ? W_W : WIDTH_CFG_W;
  localparam int RB_W   = $clog2(3 * MAX_WIDTH + 4);
  localparam int CC_W   = RB_W + 1;
  localparam int ROWS_W = $clog2(MAX_ROWS + 1);

  localparam int COL_OUT_W = 12;
  localparam int ROW_OUT_W = 12;
  localparam int RGB_W     = 24;
  localparam int OUT_DATA_W = 48;

  localparam logic [1:0] CMD_START   = 2'd0;
  localparam logic [1:0] CMD_PALETTE = 2'd1;
  localparam logic [1:0] CMD_PIXEL   = 2'd2;

  localparam logic [1:0] FMT_4BPP  = 2'd0;
  localparam logic [1:0] FMT_8BPP  = 2'd1;
  localparam logic [1:0] FMT_24BPP = 2'd2;
  localparam logic [1:0] FMT_NONE  = 2'd3;

  localparam logic [CFG_ADDR_W-1:0] CFG_PIXEL_FORMAT    = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_WIDTH     = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_HEIGHT    = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_PALETTE_ENTRIES = 2'd3;

  localparam logic [1:0] LANE_ALPHA = 2'd3;

  typedef struct packed {
    logic              en;
    logic [PAL_AW-1:0] addr;
    logic [1:0]        lane;
    logic [7:0]        data;
  } pal_wr_t;

  typedef enum logic {
    CLR_SWEEP,
    CLR_DONE
  } clr_state_t;

endpackage
`default_nettype wire

@@ src/bmp_pixel_row_decoder_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmp_pixel_row_decoder_unit
// Decodes an uncompressed bitmap pixel array (4/8-bit palette, 24-bit BGR)
// from a byte stream into pixels tagged with column and top-down row.
// ----------------------------------------------------------------------------
// channel  dir  tdata                          tuser  tlast
// in_      in   data_byte                      cmd    -
// out_     out  red,green,blue,column,row      -      last_of_item
// cfg_     in   we / addr / wdata, no read-back
//
// One byte word is taken per cycle unless the decoder stalls; words flow
// through a palette read stage and an output register, and output stalls
// back up through both. A 4-bit pixel byte yields up to two pixels that
// leave one per cycle while the output is ready; the input stalls while the
// second waits. No word is taken while the palette is zeroed after reset.
// ----------------------------------------------------------------------------
module bmp_pixel_row_decoder_unit (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_tvalid,
  output logic                                in_tready,
  input  wire  [7:0]                          in_tdata,   // [7:0] data_byte
  input  wire  [1:0]                          in_tuser,   // [1:0] cmd
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  // [7:0] red, [15:8] green, [23:16] blue, [35:24] column,
  // [47:36] row_index
  output logic [bprd_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                                out_tlast,  // last_of_item
  input  wire                                 cfg_we,
  input  wire  [bprd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  wire  [bprd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  // configuration
  logic [bprd_pkg::FMT_W-1:0]        fmt_r;
  logic [bprd_pkg::WIDTH_CFG_W-1:0]  width_r;
  logic [bprd_pkg::HEIGHT_CFG_W-1:0] height_r;
  logic [bprd_pkg::ENT_CFG_W-1:0]    pal_ent_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r     <= bprd_pkg::FMT_8BPP;
      width_r   <= bprd_pkg::WIDTH_CFG_W'(1);
      height_r  <= bprd_pkg::HEIGHT_CFG_W'(1);
      pal_ent_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        bprd_pkg::CFG_PIXEL_FORMAT:    fmt_r     <= cfg_wdata[bprd_pkg::FMT_W-1:0];
        bprd_pkg::CFG_IMAGE_WIDTH:     width_r   <= cfg_wdata[bprd_pkg::WIDTH_CFG_W-1:0];
        bprd_pkg::CFG_IMAGE_HEIGHT:    height_r  <= cfg_wdata[bprd_pkg::HEIGHT_CFG_W-1:0];
        bprd_pkg::CFG_PALETTE_ENTRIES: pal_ent_r <= cfg_wdata[bprd_pkg::ENT_CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // decode state
  logic [bprd_pkg::PAL_CNT_W-1:0] pal_cnt_r, pal_cnt_nxt;
  logic [bprd_pkg::RB_W-1:0]      rbc_r, rbc_nxt;
  logic [bprd_pkg::CC_W-1:0]      col_r, col_nxt;
  logic [bprd_pkg::ROWS_W-1:0]    rows_r, rows_nxt;
  logic [15:0]                    pc_r, pc_nxt;
  logic [1:0]                     phase_r, phase_nxt;

  // read stage
  logic                              s1_valid_r, s1_valid_nxt;
  logic [1:0]                        s1_pend_r, s1_pend_nxt;
  logic [1:0]                        s1_oob_r;
  logic                              s1_direct_r;
  logic [bprd_pkg::RGB_W-1:0]        s1_rgb_r;
  logic [bprd_pkg::COL_OUT_W-1:0]    s1_col0_r, s1_col1_r;
  logic [bprd_pkg::ROW_OUT_W-1:0]    s1_row_r;

  // output register
  logic                              out_valid_r, out_valid_nxt;
  logic                              out_last_r;
  logic [bprd_pkg::RGB_W-1:0]        out_rgb_r;
  logic [bprd_pkg::COL_OUT_W-1:0]    out_col_r;
  logic [bprd_pkg::ROW_OUT_W-1:0]    out_row_r;

  // memory
  bprd_pkg::pal_wr_t             pal_wr;
  logic [bprd_pkg::PAL_AW-1:0]   rd_addr0, rd_addr1;
  logic [bprd_pkg::RGB_W-1:0]    rd_data0, rd_data1;
  logic                          ct_ready;

  // geometry
  logic [bprd_pkg::GW-1:0]           w_g;
  logic [bprd_pkg::RB_W-1:0]         w;
  logic [bprd_pkg::RB_W-1:0]         data_bytes;
  logic [bprd_pkg::RB_W:0]           padded_x;
  logic [bprd_pkg::RB_W-1:0]         padded;
  logic [bprd_pkg::HEIGHT_CFG_W-1:0] mag_h;
  logic [bprd_pkg::ROWS_W-1:0]       mag;
  logic [bprd_pkg::ROWS_W-1:0]       row;
  logic [bprd_pkg::ENT_W-1:0]        ent;
  logic [bprd_pkg::PAL_CNT_W-1:0]    pal_limit;
  logic [bprd_pkg::RB_W-1:0]         rbc_inc;
  logic [bprd_pkg::CC_W-1:0]         w_c, col_p1;

  logic in_acc, s1_move, s1_done;
  logic in_data, emit0, emit1, direct;
  logic [7:0] idx0, idx1;
  logic [bprd_pkg::RGB_W-1:0] rgb0, rgb1;

  assign in_acc  = in_tvalid && in_tready;
  assign s1_move = s1_valid_r && (!out_valid_r || out_tready);
  assign s1_done = s1_move && (s1_pend_r != 2'b11);
  assign in_tready = ct_ready && (!s1_valid_r || s1_done);

  always_comb begin
    w_g = bprd_pkg::GW'(width_r);
    if (width_r == '0) begin
      w_g = bprd_pkg::GW'(1);
    end else if (int'(width_r) > bprd_pkg::MAX_WIDTH) begin
      w_g = bprd_pkg::GW'(bprd_pkg::MAX_WIDTH);
    end
    w = bprd_pkg::RB_W'(w_g);
    case (fmt_r)
      bprd_pkg::FMT_4BPP: data_bytes = bprd_pkg::RB_W'(({1'b0, w} + 1'b1) >> 1);
      bprd_pkg::FMT_8BPP: data_bytes = w;
      default:            data_bytes = bprd_pkg::RB_W'({w, 1'b0} + {1'b0, w});
    endcase
    padded_x = ({1'b0, data_bytes} + 2'd3) & ~(bprd_pkg::RB_W + 1)'(3);
    padded   = bprd_pkg::RB_W'(padded_x);

    mag_h = height_r[bprd_pkg::HEIGHT_CFG_W-1] ? (~height_r + 1'b1) : height_r;
    mag   = (int'(mag_h) > bprd_pkg::MAX_ROWS) ? bprd_pkg::ROWS_W'(bprd_pkg::MAX_ROWS)
                                               : bprd_pkg::ROWS_W'(mag_h);
    row   = height_r[bprd_pkg::HEIGHT_CFG_W-1] ? rows_r : (mag - 1'b1 - rows_r);

    ent = bprd_pkg::ENT_W'(pal_ent_r);
    if (pal_ent_r == '0) begin
      ent = (fmt_r == bprd_pkg::FMT_4BPP) ? bprd_pkg::ENT_W'(16)
                                          : bprd_pkg::ENT_W'(bprd_pkg::PALETTE_DEPTH);
    end else if (int'(pal_ent_r) > bprd_pkg::PALETTE_DEPTH) begin
      ent = bprd_pkg::ENT_W'(bprd_pkg::PALETTE_DEPTH);
    end
    pal_limit = {ent, 2'b00};
  end

  assign rbc_inc = rbc_r + 1'b1;
  assign w_c     = bprd_pkg::CC_W'(w);
  assign col_p1  = col_r + 1'b1;
  assign in_data = (rbc_r < data_bytes);
  assign idx0    = (fmt_r == bprd_pkg::FMT_4BPP) ? {4'd0, in_tdata[7:4]} : in_tdata;
  assign idx1    = {4'd0, in_tdata[3:0]};
  assign rd_addr0 = bprd_pkg::PAL_AW'(idx0);
  assign rd_addr1 = bprd_pkg::PAL_AW'(idx1);

  always_comb begin
    pal_cnt_nxt = pal_cnt_r;
    rbc_nxt     = rbc_r;
    col_nxt     = col_r;
    rows_nxt    = rows_r;
    pc_nxt      = pc_r;
    phase_nxt   = phase_r;
    emit0       = 1'b0;
    emit1       = 1'b0;
    direct      = 1'b0;
    pal_wr.en   = 1'b0;
    pal_wr.addr = bprd_pkg::PAL_AW'(pal_cnt_r[bprd_pkg::PAL_CNT_W-1:2]);
    pal_wr.lane = pal_cnt_r[1:0];
    pal_wr.data = in_tdata;
    if (in_acc) begin
      case (in_tuser)
        bprd_pkg::CMD_START: begin
          pal_cnt_nxt = '0;
          rbc_nxt     = '0;
          col_nxt     = '0;
          rows_nxt    = '0;
          pc_nxt      = '0;
          phase_nxt   = '0;
        end
        bprd_pkg::CMD_PALETTE: begin
          if (fmt_r != bprd_pkg::FMT_NONE && pal_cnt_r < pal_limit) begin
            pal_wr.en   = 1'b1;
            pal_cnt_nxt = pal_cnt_r + 1'b1;
          end
        end
        bprd_pkg::CMD_PIXEL: begin
          if (fmt_r != bprd_pkg::FMT_NONE && rows_r < mag) begin
            if (in_data) begin
              case (fmt_r)
                bprd_pkg::FMT_4BPP: begin
                  emit0   = (col_r < w_c);
                  emit1   = (col_p1 < w_c);
                  col_nxt = col_r + 2'd2;
                end
                bprd_pkg::FMT_8BPP: begin
                  emit0   = (col_r < w_c);
                  col_nxt = col_p1;
                end
                default: begin
                  case (phase_r)
                    2'd0: begin
                      pc_nxt    = {pc_r[15:8], in_tdata};
                      phase_nxt = 2'd1;
                    end
                    2'd1: begin
                      pc_nxt    = {in_tdata, pc_r[7:0]};
                      phase_nxt = 2'd2;
                    end
                    default: begin
                      emit0     = (col_r < w_c);
                      direct    = 1'b1;
                      col_nxt   = col_p1;
                      phase_nxt = 2'd0;
                    end
                  endcase
                end
              endcase
            end
            rbc_nxt = rbc_inc;
            if (rbc_inc >= padded) begin
              rbc_nxt   = '0;
              col_nxt   = '0;
              phase_nxt = '0;
              rows_nxt  = rows_r + 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pal_cnt_r <= '0;
      rbc_r     <= '0;
      col_r     <= '0;
      rows_r    <= '0;
      pc_r      <= '0;
      phase_r   <= '0;
    end else begin
      pal_cnt_r <= pal_cnt_nxt;
      rbc_r     <= rbc_nxt;
      col_r     <= col_nxt;
      rows_r    <= rows_nxt;
      pc_r      <= pc_nxt;
      phase_r   <= phase_nxt;
    end
  end

  bprd_color_table u_color_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (pal_wr),
    .rd_en    (in_acc),
    .rd_addr0 (rd_addr0),
    .rd_addr1 (rd_addr1),
    .rd_data0 (rd_data0),
    .rd_data1 (rd_data1),
    .ready    (ct_ready)
  );

  // read stage
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_pend_nxt  = s1_pend_r;
    if (in_acc) begin
      s1_valid_nxt = emit0 || emit1;
      s1_pend_nxt  = {emit1, emit0};
    end else if (s1_done) begin
      s1_valid_nxt = 1'b0;
    end else if (s1_move) begin
      s1_pend_nxt = 2'b10;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_pend_r  <= '0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s1_pend_r  <= s1_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_oob_r    <= {int'(idx1) >= bprd_pkg::PALETTE_DEPTH,
                      int'(idx0) >= bprd_pkg::PALETTE_DEPTH};
      s1_direct_r <= direct;
      s1_rgb_r    <= {in_tdata, pc_r};
      s1_col0_r   <= bprd_pkg::COL_OUT_W'(col_r);
      s1_col1_r   <= bprd_pkg::COL_OUT_W'(col_p1);
      s1_row_r    <= bprd_pkg::ROW_OUT_W'(row);
    end
  end

  assign rgb0 = s1_direct_r ? s1_rgb_r : (s1_oob_r[0] ? '0 : rd_data0);
  assign rgb1 = s1_oob_r[1] ? '0 : rd_data1;

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_move) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_last_r <= (s1_pend_r != 2'b11);
      out_row_r  <= s1_row_r;
      if (s1_pend_r[0]) begin
        out_rgb_r <= rgb0;
        out_col_r <= s1_col0_r;
      end else begin
        out_rgb_r <= rgb1;
        out_col_r <= s1_col1_r;
      end
    end
  end

  // table entries hold B in the low byte, R in the high byte
  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {out_row_r, out_col_r,
                       out_rgb_r[7:0], out_rgb_r[15:8], out_rgb_r[23:16]};

endmodule
`default_nettype wire

@@ src/bprd_color_table.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bprd_color_table
// Palette memory: byte-lane writes, two registered read ports, and a
// zeroing sweep after reset.
// ----------------------------------------------------------------------------
module bprd_color_table (
  input  wire                           clk,
  input  wire                           rst_n,
  input  bprd_pkg::pal_wr_t             wr,
  input  wire                           rd_en,
  input  wire  [bprd_pkg::PAL_AW-1:0]   rd_addr0,
  input  wire  [bprd_pkg::PAL_AW-1:0]   rd_addr1,
  output logic [bprd_pkg::RGB_W-1:0]    rd_data0,
  output logic [bprd_pkg::RGB_W-1:0]    rd_data1,
  output logic                          ready
);

  logic [bprd_pkg::RGB_W-1:0]  mem [bprd_pkg::PALETTE_DEPTH];

  bprd_pkg::clr_state_t        state_r, state_nxt;
  logic [bprd_pkg::PAL_AW-1:0] clr_addr_r, clr_addr_nxt;
  logic                        clr_we;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= bprd_pkg::CLR_SWEEP;
      clr_addr_r <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    clr_we       = 1'b0;
    ready        = 1'b0;
    case (state_r)
      bprd_pkg::CLR_SWEEP: begin
        clr_we       = 1'b1;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == bprd_pkg::PAL_AW'(bprd_pkg::PALETTE_DEPTH - 1)) begin
          state_nxt    = bprd_pkg::CLR_DONE;
          clr_addr_nxt = '0;
        end
      end
      bprd_pkg::CLR_DONE: begin
        ready = 1'b1;
      end
      default: begin
        state_nxt = bprd_pkg::CLR_SWEEP;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (clr_we) begin
      mem[clr_addr_r] <= '0;
    end else if (wr.en && wr.lane != bprd_pkg::LANE_ALPHA) begin
      mem[wr.addr][8*wr.lane +: 8] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data0 <= mem[rd_addr0];
      rd_data1 <= mem[rd_addr1];
    end
  end

endmodule
`default_nettype wire

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for bmp_pixel_row_decoder_unit. Streams palette and
// pixel words through all pixel formats and row orders, with random idling on
// both sides. Each decoded pixel is predicted in order and compared field by
// field with the output stream.
// ----------------------------------------------------------------------------
module tb;
  import bprd_pkg::*;

  localparam int QUIET_LIMIT   = 3000;
  localparam int SETTLE_CYCLES = 16;
  localparam int TAIL_CYCLES   = 32;
  localparam int RANDOM_WORDS  = 880;
  localparam int PART_ENTRIES  = 24;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [11:0] column;
    logic [11:0] row;
    logic        last;
  } pixel_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [7:0]            in_tdata;   // [7:0] data_byte
  logic [1:0]            in_tuser;   // [1:0] cmd
  logic                  out_tvalid;
  logic                  out_tready;
  // [7:0] red, [15:8] green, [23:16] blue, [35:24] column, [47:36] row_index
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // decoder shadow state
  logic [23:0] pal_rgb [PALETTE_DEPTH];
  int          pal_fill;
  int          row_fill;
  int          next_col;
  int          rows_out;
  int          bgr_step;
  logic [15:0] bg_hold;
  logic [1:0]  cur_fmt;
  logic [12:0] cur_width;
  logic [13:0] cur_height;
  logic [8:0]  cur_entries;

  pixel_t expected_pixels[$];
  int     words_sent = 0;
  int     pixels_checked = 0;
  int     images = 0;
  int     mismatches = 0;
  int     quiet_cycles = 0;
  bit     calm = 1'b0;

  bmp_pixel_row_decoder_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_tready <= calm || ($urandom_range(99) >= 8);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("bmp_pixel_row_decoder_unit test failed");
        $finish;
      end
    end
  end

  function automatic void flag_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH: %s", msg);
  endfunction

  always @(posedge clk) begin : pixel_check
    pixel_t want;
    pixel_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.red    = out_tdata[7:0];
      got.green  = out_tdata[15:8];
      got.blue   = out_tdata[23:16];
      got.column = out_tdata[35:24];
      got.row    = out_tdata[47:36];
      got.last   = out_tlast;
      if (expected_pixels.size() == 0) begin
        flag_mismatch($sformatf("unexpected pixel col %0d row %0d rgb %02h%02h%02h last %b",
                                got.column, got.row, got.red, got.green, got.blue, got.last));
      end else begin
        want = expected_pixels.pop_front();
        pixels_checked++;
        if (got !== want) begin
          flag_mismatch($sformatf({"want col %0d row %0d rgb %02h%02h%02h last %b, ",
                                   "got col %0d row %0d rgb %02h%02h%02h last %b"},
                                  want.column, want.row, want.red, want.green, want.blue,
                                  want.last, got.column, got.row, got.red, got.green,
                                  got.blue, got.last));
        end
      end
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic void row_geometry(output int w, output int depth, output int data_len,
                                       output int span);
    logic [13:0] neg_h;
    neg_h = -cur_height;
    w = (cur_width == 0) ? 1 : int'(cur_width);
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    depth = cur_height[13] ? int'(neg_h) : int'(cur_height);
    if (depth > MAX_ROWS) depth = MAX_ROWS;
    case (cur_fmt)
      FMT_4BPP: data_len = (w + 1) / 2;
      FMT_8BPP: data_len = w;
      default:  data_len = 3 * w;
    endcase
    span = (data_len + 3) / 4 * 4;
  endfunction

  function automatic void push_pixel(logic [23:0] rgb, int col, int row);
    pixel_t px;
    px.red    = rgb[23:16];
    px.green  = rgb[15:8];
    px.blue   = rgb[7:0];
    px.column = 12'(col);
    px.row    = 12'(row);
    px.last   = 1'b0;
    expected_pixels.push_back(px);
  endfunction

  function automatic void load_palette_word(logic [7:0] b);
    int slots;
    if (cur_fmt == FMT_NONE) return;
    slots = int'(cur_entries);
    if (slots == 0) slots = (cur_fmt == FMT_4BPP) ? 16 : PALETTE_DEPTH;
    if (slots > PALETTE_DEPTH) slots = PALETTE_DEPTH;
    if (pal_fill >= 4 * slots) return;
    case (pal_fill % 4)
      0:       pal_rgb[pal_fill / 4][7:0]   = b;
      1:       pal_rgb[pal_fill / 4][15:8]  = b;
      2:       pal_rgb[pal_fill / 4][23:16] = b;
      default: ;  // alpha dropped
    endcase
    pal_fill++;
  endfunction

  function automatic void decode_pixel_word(logic [7:0] b);
    int     w;
    int     depth;
    int     data_len;
    int     span;
    int     row;
    int     queued;
    pixel_t px;
    if (cur_fmt == FMT_NONE) return;
    row_geometry(w, depth, data_len, span);
    if (rows_out >= depth) return;
    row = cur_height[13] ? rows_out : depth - 1 - rows_out;
    queued = expected_pixels.size();
    if (row_fill < data_len) begin
      case (cur_fmt)
        FMT_4BPP: begin
          if (next_col < w) push_pixel(pal_rgb[b[7:4]], next_col, row);
          if (next_col + 1 < w) push_pixel(pal_rgb[b[3:0]], next_col + 1, row);
          next_col += 2;
        end
        FMT_8BPP: begin
          if (next_col < w) push_pixel(pal_rgb[b], next_col, row);
          next_col++;
        end
        default: begin
          if (bgr_step == 0) begin
            bg_hold[7:0] = b;
            bgr_step = 1;
          end else if (bgr_step == 1) begin
            bg_hold[15:8] = b;
            bgr_step = 2;
          end else begin
            if (next_col < w) push_pixel({b, bg_hold}, next_col, row);
            next_col++;
            bgr_step = 0;
          end
        end
      endcase
    end
    row_fill++;
    if (row_fill >= span) begin
      row_fill = 0;
      next_col = 0;
      bgr_step = 0;
      rows_out++;
    end
    if (expected_pixels.size() > queued) begin
      px = expected_pixels.pop_back();
      px.last = 1'b1;
      expected_pixels.push_back(px);
    end
  endfunction

  function automatic void predict_word(logic [1:0] cmd, logic [7:0] b);
    case (cmd)
      CMD_START: begin
        pal_fill = 0;
        row_fill = 0;
        next_col = 0;
        rows_out = 0;
        bgr_step = 0;
        bg_hold  = '0;
      end
      CMD_PALETTE: load_palette_word(b);
      CMD_PIXEL:   decode_pixel_word(b);
      default:     ;
    endcase
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic send_word(input logic [1:0] cmd, input logic [7:0] data);
    if (!calm && $urandom_range(99) < 8) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= data;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_word(cmd, data);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (expected_pixels.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    case (addr)
      CFG_PIXEL_FORMAT:    cur_fmt     = value[1:0];
      CFG_IMAGE_WIDTH:     cur_width   = value[12:0];
      CFG_IMAGE_HEIGHT:    cur_height  = value[13:0];
      CFG_PALETTE_ENTRIES: cur_entries = value[8:0];
      default:             ;
    endcase
  endtask

  // bits above each narrower register's width carry junk
  task automatic configure(input logic [1:0] f, input int w, input int h, input int e);
    drain();
    write_reg(CFG_PIXEL_FORMAT, {12'($urandom), f});
    write_reg(CFG_IMAGE_WIDTH, {1'($urandom), 13'(w)});
    write_reg(CFG_IMAGE_HEIGHT, 14'(h));
    write_reg(CFG_PALETTE_ENTRIES, {5'($urandom), 9'(e)});
  endtask

  task automatic new_image(input logic [1:0] f, input int w, input int h, input int e);
    configure(f, w, h, e);
    images++;
    send_word(CMD_START, 8'($urandom));
  endtask

  task automatic send_run(input logic [1:0] cmd, input int count);
    repeat (count) send_word(cmd, 8'($urandom));
  endtask

  // ---------------------------------------------------------------- tests

  // reset config: 8-bit, one pixel, one row, table all black
  task automatic test_reset_state();
    images++;
    send_word(CMD_START, 8'h00);
    send_word(CMD_PIXEL, 8'hFF);
    send_run(CMD_PIXEL, 3);
    send_word(CMD_PIXEL, 8'h00);   // image complete, dropped
    send_word(CMD_UNUSED, 8'hFF);
  endtask

  task automatic test_directed_formats();
    // 4-bit, odd width drops the trailing nibble, top-down
    new_image(FMT_4BPP, 3, -2, 1);
    send_word(CMD_PALETTE, 8'hFF);
    send_word(CMD_PALETTE, 8'h00);
    send_word(CMD_PALETTE, 8'hA5);
    send_word(CMD_PALETTE, 8'h5A);
    send_word(CMD_PALETTE, 8'h3C);  // beyond the entry count
    send_word(CMD_PIXEL, 8'h0F);
    send_word(CMD_PIXEL, 8'hF0);
    send_run(CMD_PIXEL, 2);
    // 24-bit, bottom-up
    new_image(FMT_24BPP, 1, 2, 0);
    send_word(CMD_PIXEL, 8'h00);
    send_word(CMD_PIXEL, 8'hFF);
    send_word(CMD_PIXEL, 8'h80);
    send_run(CMD_PIXEL, 1);
    // undefined format ignores everything
    configure(FMT_NONE, 4, 1, 1);
    send_word(CMD_PALETTE, 8'h12);
    send_word(CMD_PIXEL, 8'h34);
    // zero height
    configure(FMT_8BPP, 4, 0, 1);
    send_word(CMD_PIXEL, 8'h00);
  endtask

  task automatic test_geometry_limits();
    // width zero, most negative height, entries above the table size
    new_image(FMT_8BPP, 0, -8192, 511);
    send_run(CMD_PIXEL, 4);
    // oversized width, largest positive height: row index at the top of range
    new_image(FMT_8BPP, 8191, 8191, 256);
    send_run(CMD_PIXEL, 3);
  endtask

  // partial palette with overrun, then indexes over loaded and unloaded entries
  task automatic test_palette_overrun();
    new_image(FMT_8BPP, 16, -4, PART_ENTRIES);
    send_run(CMD_PALETTE, 4 * PART_ENTRIES + 3);
    for (int i = 0; i < 64; i++) send_word(CMD_PIXEL, 8'(i * 4));
  endtask

  task automatic test_random_images();
    int goal;
    int pick;
    int w;
    int h;
    int e;
    int depth;
    int data_len;
    int span;
    logic [1:0] f;
    goal = words_sent + RANDOM_WORDS;
    while (words_sent < goal) begin
      calm = (images >= 12 && images < 22);
      pick = $urandom_range(99);
      if (pick < 78) begin
        f = ($urandom_range(99) < 3) ? FMT_NONE : 2'($urandom_range(2));
        w = $urandom_range(9, 1);
        h = $urandom_range(3, 1);
        if ($urandom_range(1)) h = -h;
        if ($urandom_range(99) < 5) h = 0;
        e = $urandom_range(16, 1);
        if (f == FMT_4BPP && $urandom_range(99) < 15) e = 0;
        new_image(f, w, h, e);
        send_run(CMD_PALETTE, 4 * ((e == 0) ? 16 : e) + $urandom_range(2));
        row_geometry(w, depth, data_len, span);
        send_run(CMD_PIXEL, depth * span + $urandom_range(1));
      end else if (pick < 86) begin
        // reshape an image half way through, no restart
        new_image(2'($urandom_range(2)), $urandom_range(8, 1), -4, $urandom_range(16, 1));
        send_run(CMD_PIXEL, $urandom_range(12, 2));
        configure(2'($urandom_range(2)), $urandom_range(8, 1), $urandom_range(4, 1),
                  $urandom_range(16, 1));
        send_run(CMD_PIXEL, $urandom_range(24, 4));
      end else if (pick < 93) begin
        h = $urandom_range(1) ? $urandom_range(8191, 4090) : -$urandom_range(8192, 4090);
        new_image(2'($urandom_range(2)), $urandom_range(2, 1), h, $urandom_range(16, 1));
        row_geometry(w, depth, data_len, span);
        send_run(CMD_PIXEL, 3 * span);
      end else begin
        new_image(2'($urandom_range(3)), $urandom_range(5, 1), $urandom_range(6) - 3,
                  $urandom_range(8));
        repeat (16) send_word(2'($urandom_range(3)), 8'($urandom));
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = CMD_START;
    out_tready = 1'b1;
    cfg_we     = 1'b0;
    cfg_addr   = CFG_PIXEL_FORMAT;
    cfg_wdata  = '0;
    for (int i = 0; i < PALETTE_DEPTH; i++) pal_rgb[i] = '0;
    pal_fill    = 0;
    row_fill    = 0;
    next_col    = 0;
    rows_out    = 0;
    bgr_step    = 0;
    bg_hold     = '0;
    cur_fmt     = FMT_8BPP;
    cur_width   = 13'd1;
    cur_height  = 14'd1;
    cur_entries = 9'd0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_directed_formats();
    test_geometry_limits();
    test_palette_overrun();
    test_random_images();

    in_tvalid <= 1'b0;
    @(negedge clk);
    while (expected_pixels.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Sent %0d words over %0d images (4/8/24-bit, both row orders, odd geometry);",
             words_sent, images);
    $display("checked %0d pixels, %0d mismatches.", pixels_checked, mismatches);
    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("bmp_pixel_row_decoder_unit test passed");
    end else begin
      $display("bmp_pixel_row_decoder_unit test failed");
    end
    $finish;
  end

endmodule
